### rtl/adlc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and the controller-to-datapath command type for
// the record/playback drift controller. No dependencies.
package adlc_pkg;

    localparam int POS_W  = 20;            // cursor and latency width
    localparam int STEP_W = POS_W + 1;     // record step, count, buffer length
    localparam int FRAC_W = 16;            // fraction bits of the gap filter
    localparam int ACC_W  = POS_W + FRAC_W + 6;
    localparam int RATE_W = 18;
    localparam int MUL_A_W = ACC_W - FRAC_W;
    localparam int MUL_B_W = RATE_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // 0.97 and 0.03 in Q16
    localparam logic [MUL_B_W-1:0] DAMP_Q     = MUL_B_W'(63570);
    localparam logic [MUL_B_W-1:0] ONE_M_DAMP = MUL_B_W'(1966);
    // x / 50 == (x * DIV50_M) >> DIV50_SH for every 18-bit x
    localparam logic [MUL_B_W-1:0] DIV50_M    = MUL_B_W'(335545);
    localparam int DIV50_SH = 24;

    localparam logic [STEP_W-1:0] BUF_LEN_RST  = STEP_W'(220500);
    localparam logic [POS_W-1:0]  BASE_LAT_RST = POS_W'(882);
    localparam logic [POS_W-1:0]  THRESH_RST   = POS_W'(441);
    localparam logic [RATE_W-1:0] SRATE_RST    = RATE_W'(44100);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUF_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LAT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRATE    = 2'd3;

    localparam logic [1:0] RATE_NORMAL = 2'd0;
    localparam logic [1:0] RATE_SLOW   = 2'd1;
    localparam logic [1:0] RATE_FAST   = 2'd2;
    localparam logic [1:0] RATE_NONE   = 2'd3;

    typedef struct packed {
        logic load_in;   // capture the cursors of an accepted item
        logic prep;      // step, count, start, latency, gap
        logic mul_lo;    // low half of acc * decay
        logic acc_upd;   // fold the new gap into the filter
        logic sq_hi;     // high half of acc * (1 - decay)
        logic sq_lo;     // low half of acc * (1 - decay)
        logic fin;       // smoothed value complete
        logic out_load;  // result register takes the item
    } cmd_t;

endpackage

### rtl/adlc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for cursor polls and drift results.
// Depends on adlc_pkg.
interface adlc_poll_if;
    logic                          valid;
    logic                          ready;
    logic [adlc_pkg::POS_W-1:0]    record_pos;
    logic [adlc_pkg::POS_W-1:0]    play_pos;

    modport source (output valid, output record_pos, output play_pos, input ready);
    modport sink   (input valid, input record_pos, input play_pos, output ready);
endinterface

interface adlc_result_if;
    logic                          valid;
    logic                          ready;
    logic                          start_playback;
    logic [1:0]                    rate_code;
    logic [adlc_pkg::RATE_W-1:0]   playback_rate;
    logic [adlc_pkg::POS_W-1:0]    latency_now;
    logic [adlc_pkg::POS_W-1:0]    smoothed_gap;

    modport source (output valid, output start_playback, output rate_code,
                    output playback_rate, output latency_now, output smoothed_gap,
                    input ready);
    modport sink   (input valid, input start_playback, input rate_code,
                    input playback_rate, input latency_now, input smoothed_gap,
                    output ready);
endinterface

### rtl/adlc_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the drift controller: steps the datapath through one item
// and owns the channel handshakes. Depends on adlc_pkg.
module adlc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             out_ready,
    output logic             in_ready,
    output logic             out_valid,
    output adlc_pkg::cmd_t   cmd
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_PREP   = 8'b0000_0010,
        ST_MUL_LO = 8'b0000_0100,
        ST_ACC    = 8'b0000_1000,
        ST_SQ_HI  = 8'b0001_0000,
        ST_SQ_LO  = 8'b0010_0000,
        ST_FIN    = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept, slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_PREP;
            ST_PREP:   state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_ACC;
            ST_ACC:    state_next = ST_SQ_HI;
            ST_SQ_HI:  state_next = ST_SQ_LO;
            ST_SQ_LO:  state_next = ST_FIN;
            ST_FIN:    state_next = ST_OUT;
            ST_OUT:    if (slot_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.load_in  = accept;
        cmd.prep     = (state_reg == ST_PREP);
        cmd.mul_lo   = (state_reg == ST_MUL_LO);
        cmd.acc_upd  = (state_reg == ST_ACC);
        cmd.sq_hi    = (state_reg == ST_SQ_HI);
        cmd.sq_lo    = (state_reg == ST_SQ_LO);
        cmd.fin      = (state_reg == ST_FIN);
        cmd.out_load = (state_reg == ST_OUT) && slot_free;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/adlc_datapath.sv
`timescale 1ns / 1ps
// Datapath of the drift controller: configuration registers, cursor state,
// the shared multiplier, the gap filter and the rate decision.
// Depends on adlc_pkg.
module adlc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [adlc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [adlc_pkg::STEP_W-1:0]         cfg_data,
    input  adlc_pkg::cmd_t                      cmd,
    input  logic [adlc_pkg::POS_W-1:0]          record_pos,
    input  logic [adlc_pkg::POS_W-1:0]          play_pos,
    output logic                                start_playback,
    output logic [1:0]                          rate_code,
    output logic [adlc_pkg::RATE_W-1:0]         playback_rate,
    output logic [adlc_pkg::POS_W-1:0]          latency_now,
    output logic [adlc_pkg::POS_W-1:0]          smoothed_gap
);

    localparam int PW = adlc_pkg::POS_W;
    localparam int SW = adlc_pkg::STEP_W;
    localparam int FW = adlc_pkg::FRAC_W;
    localparam int AW = adlc_pkg::ACC_W;
    localparam int RW = adlc_pkg::RATE_W;
    localparam int MAW = adlc_pkg::MUL_A_W;
    localparam int MBW = adlc_pkg::MUL_B_W;
    localparam int PRW = adlc_pkg::PROD_W;

    // configuration
    logic [SW-1:0] buf_len_reg;
    logic [PW-1:0] thresh_reg;
    logic [RW-1:0] srate_reg;

    // persistent state
    logic [PW-1:0] last_rec_reg, last_rec_next;
    logic [SW-1:0] count_reg, count_next;
    logic          playing_reg, playing_next;
    logic [SW-1:0] min_step_reg, min_step_next;
    logic [PW-1:0] lat_reg, lat_next;
    logic [AW-1:0] acc_reg, acc_next;

    // per-item working registers
    logic [PW-1:0]  rec_reg, ply_reg;
    logic [SW-1:0]  gap_reg, gap_next;
    logic           upd_reg, upd_next;
    logic           start_reg, start_next;
    logic [PRW-1:0] prod_reg, prod_next;
    logic [AW-1:0]  part_reg;
    logic [AW-1:0]  sq_reg;
    logic [RW-1:0]  div_reg;

    // result register
    logic          start_o_reg;
    logic [1:0]    code_o_reg, code_o_next;
    logic [RW-1:0] rate_o_reg, rate_o_next;
    logic [PW-1:0] lat_o_reg;
    logic [PW-1:0] sg_o_reg, sg_o_next;

    logic [MAW-1:0] mul_a;
    logic [MBW-1:0] mul_b;
    logic [SW-1:0]  step;
    logic [SW:0]    count_sum;
    logic [AW+1:0]  acc_sum;

    function automatic logic [SW-1:0] wrap_diff(input logic [PW-1:0] a,
                                                 input logic [PW-1:0] b,
                                                 input logic [SW-1:0] len);
        logic [SW:0] ext;
        begin
            ext = {2'b00, a} + {1'b0, len};
            if (a >= b)
                return {1'b0, a - b};
            else if (ext >= {2'b00, b})
                return SW'(ext - {2'b00, b});
            else
                return '0;
        end
    endfunction

    // ---------------- shared multiplier ----------------
    always_comb
    begin
        mul_a = acc_reg[AW-1:FW];
        mul_b = adlc_pkg::DAMP_Q;
        priority if (cmd.prep)
        begin
            mul_a = acc_reg[AW-1:FW];
            mul_b = adlc_pkg::DAMP_Q;
        end
        else if (cmd.mul_lo)
        begin
            mul_a = MAW'(acc_reg[FW-1:0]);
            mul_b = adlc_pkg::DAMP_Q;
        end
        else if (cmd.acc_upd)
        begin
            mul_a = MAW'(srate_reg);
            mul_b = adlc_pkg::DIV50_M;
        end
        else if (cmd.sq_hi)
        begin
            mul_a = acc_reg[AW-1:FW];
            mul_b = adlc_pkg::ONE_M_DAMP;
        end
        else if (cmd.sq_lo)
        begin
            mul_a = MAW'(acc_reg[FW-1:0]);
            mul_b = adlc_pkg::ONE_M_DAMP;
        end
        else
        begin
            mul_a = acc_reg[AW-1:FW];
            mul_b = adlc_pkg::DAMP_Q;
        end
    end

    assign prod_next = PRW'(mul_a) * PRW'(mul_b);

    // ---------------- cursor bookkeeping ----------------
    always_comb
    begin
        step          = wrap_diff(rec_reg, last_rec_reg, buf_len_reg);
        count_sum     = {1'b0, count_reg} + {1'b0, step};
        count_next    = count_sum[SW] ? {SW{1'b1}} : count_sum[SW-1:0];
        start_next    = !playing_reg && (count_next >= {1'b0, lat_reg});
        playing_next  = playing_reg || start_next;
        upd_next      = playing_next && (step != '0);
        gap_next      = wrap_diff(rec_reg, ply_reg, buf_len_reg);
        last_rec_next = rec_reg;
        min_step_next = min_step_reg;
        lat_next      = lat_reg;
        if (upd_next && (step < min_step_reg))
        begin
            min_step_next = step;
            if ({1'b0, lat_reg} < step)
                lat_next = step[SW-1] ? {PW{1'b1}} : step[PW-1:0];
        end
    end

    // ---------------- gap filter ----------------
    always_comb
    begin
        acc_sum  = {2'b00, part_reg} + (AW+2)'(prod_reg[2*FW-1:FW])
                 + (AW+2)'({gap_reg, {FW{1'b0}}});
        acc_next = acc_reg;
        if (upd_reg)
            acc_next = (acc_sum[AW+1:AW] != 2'b00) ? {AW{1'b1}} : acc_sum[AW-1:0];
    end

    // ---------------- rate decision ----------------
    always_comb
    begin
        logic          slow;
        logic          fast;
        logic [PW-1:0] lat_diff;
        logic [SW-1:0] lat_hi;
        logic [RW:0]   fast_sum;
        begin
            lat_diff = lat_reg - thresh_reg;
            lat_hi   = {1'b0, lat_reg} + {1'b0, thresh_reg};
            slow     = (gap_reg > {1'b0, buf_len_reg[SW-1:1]})
                    || ((lat_reg >= thresh_reg)
                        && (sq_reg < AW'({lat_diff, {FW{1'b0}}})));
            fast     = gap_reg > lat_hi;
            fast_sum = {1'b0, srate_reg} + {1'b0, div_reg};
            if (!upd_reg)
            begin
                code_o_next = adlc_pkg::RATE_NONE;
                rate_o_next = '0;
            end
            else if (slow)
            begin
                code_o_next = adlc_pkg::RATE_SLOW;
                rate_o_next = srate_reg - div_reg;
            end
            else if (fast)
            begin
                code_o_next = adlc_pkg::RATE_FAST;
                rate_o_next = fast_sum[RW] ? {RW{1'b1}} : fast_sum[RW-1:0];
            end
            else
            begin
                code_o_next = adlc_pkg::RATE_NORMAL;
                rate_o_next = srate_reg;
            end
            // integer part, clamped to cursor width
            sg_o_next = (sq_reg[AW-1:PW+FW] != '0) ? {PW{1'b1}}
                                                    : sq_reg[PW+FW-1:FW];
        end
    end

    // ---------------- registers with reset ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_len_reg  <= adlc_pkg::BUF_LEN_RST;
            thresh_reg   <= adlc_pkg::THRESH_RST;
            srate_reg    <= adlc_pkg::SRATE_RST;
            last_rec_reg <= '0;
            count_reg    <= '0;
            playing_reg  <= 1'b0;
            min_step_reg <= {SW{1'b1}};
            lat_reg      <= adlc_pkg::BASE_LAT_RST;
            acc_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    adlc_pkg::CFG_BUF_LEN:  buf_len_reg <= cfg_data;
                    adlc_pkg::CFG_BASE_LAT: lat_reg     <= cfg_data[PW-1:0];
                    adlc_pkg::CFG_THRESH:   thresh_reg  <= cfg_data[PW-1:0];
                    adlc_pkg::CFG_SRATE:    srate_reg   <= cfg_data[RW-1:0];
                    default: ;
                endcase
            end
            if (cmd.prep)
            begin
                last_rec_reg <= last_rec_next;
                count_reg    <= count_next;
                playing_reg  <= playing_next;
                min_step_reg <= min_step_next;
                lat_reg      <= lat_next;
            end
            if (cmd.acc_upd)
                acc_reg <= acc_next;
        end
    end

    // ---------------- working and result registers ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            rec_reg <= record_pos;
            ply_reg <= play_pos;
        end
        if (cmd.prep)
        begin
            gap_reg   <= gap_next;
            upd_reg   <= upd_next;
            start_reg <= start_next;
        end
        if (cmd.prep || cmd.mul_lo || cmd.acc_upd || cmd.sq_hi || cmd.sq_lo)
            prod_reg <= prod_next;
        if (cmd.mul_lo || cmd.sq_lo)
            part_reg <= prod_reg[AW-1:0];
        if (cmd.sq_hi)
            div_reg <= prod_reg[adlc_pkg::DIV50_SH+RW-1:adlc_pkg::DIV50_SH];
        if (cmd.fin)
            sq_reg <= part_reg + AW'(prod_reg[2*FW-1:FW]);
        if (cmd.out_load)
        begin
            start_o_reg <= start_reg;
            code_o_reg  <= code_o_next;
            rate_o_reg  <= rate_o_next;
            lat_o_reg   <= lat_reg;
            sg_o_reg    <= sg_o_next;
        end
    end

    assign start_playback = start_o_reg;
    assign rate_code      = code_o_reg;
    assign playback_rate  = rate_o_reg;
    assign latency_now    = lat_o_reg;
    assign smoothed_gap   = sg_o_reg;

endmodule

### rtl/audio_loopback_drift_control.sv
`timescale 1ns / 1ps
// Top level of the record/playback drift controller.
// Depends on adlc_pkg, adlc_if, adlc_ctrl and adlc_datapath.
//
// Usage:
//   poll   - one item per poll of the circular buffer: record and play cursor.
//   result - one item per poll: start flag, rate code, playback rate,
//            adjusted latency and the integer part of the smoothed gap.
//   cfg_we/cfg_index/cfg_data - register writes (buffer length, base latency,
//            drift threshold, sample rate); write only while no poll is in
//            flight. Writing base latency also reloads the adjusted latency.
// Timing: a poll is taken in the idle state, and its result is registered
//   in the output step; no new poll is taken before then. The steps are set
//   by the single 26x19 multiplier, used five times per item (two halves of
//   the decay product, the divide by 50, two halves of the smoothing product).
// The result sits in an output register: a new poll is accepted while the
//   previous result still waits; if the receiver stalls, the next item holds
//   in its final step until the register is free.
// Reset: cursor state, count and filter cleared, playback stopped, minimum
//   step all ones, registers and adjusted latency back to their defaults.
module audio_loopback_drift_control (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [adlc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [adlc_pkg::STEP_W-1:0]      cfg_data,
    adlc_poll_if.sink                        poll,
    adlc_result_if.source                    result
);

    adlc_pkg::cmd_t cmd;
    logic           in_ready;
    logic           out_valid;

    adlc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (poll.valid),
        .out_ready (result.ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    adlc_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .record_pos     (poll.record_pos),
        .play_pos       (poll.play_pos),
        .start_playback (result.start_playback),
        .rate_code      (result.rate_code),
        .playback_rate  (result.playback_rate),
        .latency_now    (result.latency_now),
        .smoothed_gap   (result.smoothed_gap)
    );

    assign poll.ready   = in_ready;
    assign result.valid = out_valid;

endmodule
